[rtl/core/bfpa_pkg.sv]
// shared types and constants of the beacon frame parser
`default_nettype none

package bfpa_pkg;

    // parser states
    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_OPP0 = 4'd1,
        ST_OPP1 = 4'd2,
        ST_OPP2 = 4'd3,
        ST_OPP3 = 4'd4,
        ST_POS0 = 4'd5,
        ST_POS1 = 4'd6,
        ST_POS2 = 4'd7,
        ST_POS3 = 4'd8,
        ST_POS4 = 4'd9,
        ST_POS5 = 4'd10
    } parse_state_t;

    // command bytes
    localparam logic [7:0] CMD_OPP = 8'h00;
    localparam logic [7:0] CMD_POS = 8'h01;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPP_AGE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_AGE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET  = 2'd2;
    localparam int CFG_DATA_W = 12;

    // configuration reset values
    localparam logic [7:0]  OPP_AGE_LIMIT_RST = 8'd50;
    localparam logic [7:0]  POS_AGE_LIMIT_RST = 8'd3;
    localparam logic [11:0] ANGLE_OFFSET_RST  = 12'd449;

    // age after reset, never below any limit
    localparam logic [7:0] AGE_ABSENT = 8'hFF;

    // angle wrap and divide by ten (x * 0xCCCD >> 19 is exact for 16-bit x)
    localparam logic [14:0] ANGLE_WRAP = 15'd3600;
    localparam logic [15:0] DEG_RECIP  = 16'hCCCD;
    localparam int          DEG_SHIFT  = 19;

    typedef struct packed {
        logic opp_done;
        logic pos_done;
    } parse_evt_t;

    typedef struct packed {
        logic [13:0] distance;
        logic [13:0] angle;
        logic [13:0] x;
        logic [13:0] y;
        logic [13:0] heading;
    } latch_t;

    typedef struct packed {
        logic        present;
        logic [13:0] distance;
        logic [14:0] angle_tenths;
        logic [10:0] angle_degrees;
    } opp_pub_t;

    typedef struct packed {
        logic        present;
        logic [13:0] x;
        logic [13:0] y;
        logic [13:0] angle;
    } pos_pub_t;

endpackage

`default_nettype wire

[rtl/core/bfpa_if.sv]
// request and result channel interfaces
`default_nettype none

interface bfpa_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface bfpa_res_if;
    logic        valid;
    logic        ready;
    logic        opp_present;
    logic [13:0] opp_distance;
    logic [14:0] opp_angle_tenths;
    logic [10:0] opp_angle_degrees;
    logic        pos_present;
    logic [13:0] pos_x_out;
    logic [13:0] pos_y_out;
    logic [13:0] pos_angle_out;
    logic        opp_frame_done;
    logic        pos_frame_done;

    modport source (
        output valid, output opp_present, output opp_distance, output opp_angle_tenths,
        output opp_angle_degrees, output pos_present, output pos_x_out, output pos_y_out,
        output pos_angle_out, output opp_frame_done, output pos_frame_done,
        input ready
    );
    modport sink (
        input valid, input opp_present, input opp_distance, input opp_angle_tenths,
        input opp_angle_degrees, input pos_present, input pos_x_out, input pos_y_out,
        input pos_angle_out, input opp_frame_done, input pos_frame_done,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/bfpa_parser.sv]
// frame parser: command decode, 7-bit payload assembly and frame latches
`default_nettype none

module bfpa_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_step,
    input  wire logic [7:0]          rx_byte,
    output bfpa_pkg::parse_evt_t     evt,
    output bfpa_pkg::latch_t         latch
);

    bfpa_pkg::parse_state_t state_reg, state_next;
    logic [13:0] acc_dist_reg, acc_dist_next;
    logic [6:0]  acc_angle_reg, acc_angle_next;
    logic [13:0] acc_x_reg, acc_x_next;
    logic [13:0] acc_y_reg, acc_y_next;
    logic [6:0]  acc_heading_reg, acc_heading_next;
    bfpa_pkg::latch_t latch_reg, latch_next;
    bfpa_pkg::parse_state_t state_eff;
    logic [6:0] pay;

    assign pay = rx_byte[6:0];

    always_comb
    begin
        // a byte with bit 7 clear aborts any frame and is read as a command
        state_eff        = rx_byte[7] ? state_reg : bfpa_pkg::ST_IDLE;
        state_next       = state_reg;
        acc_dist_next    = acc_dist_reg;
        acc_angle_next   = acc_angle_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        acc_heading_next = acc_heading_reg;
        latch_next       = latch_reg;
        evt              = '0;
        unique case (state_eff)
            bfpa_pkg::ST_IDLE:
            begin
                if (rx_byte == bfpa_pkg::CMD_OPP)
                    state_next = bfpa_pkg::ST_OPP0;
                else if (rx_byte == bfpa_pkg::CMD_POS)
                    state_next = bfpa_pkg::ST_POS0;
                else
                    state_next = bfpa_pkg::ST_IDLE;
            end
            bfpa_pkg::ST_OPP0:
            begin
                acc_dist_next = {7'd0, pay};
                state_next    = bfpa_pkg::ST_OPP1;
            end
            bfpa_pkg::ST_OPP1:
            begin
                acc_dist_next = {pay, acc_dist_reg[6:0]};
                state_next    = bfpa_pkg::ST_OPP2;
            end
            bfpa_pkg::ST_OPP2:
            begin
                acc_angle_next = pay;
                state_next     = bfpa_pkg::ST_OPP3;
            end
            bfpa_pkg::ST_OPP3:
            begin
                latch_next.distance = acc_dist_reg;
                latch_next.angle    = {pay, acc_angle_reg};
                evt.opp_done        = byte_step;
                state_next          = bfpa_pkg::ST_IDLE;
            end
            bfpa_pkg::ST_POS0:
            begin
                acc_x_next = {7'd0, pay};
                state_next = bfpa_pkg::ST_POS1;
            end
            bfpa_pkg::ST_POS1:
            begin
                acc_x_next = {pay, acc_x_reg[6:0]};
                state_next = bfpa_pkg::ST_POS2;
            end
            bfpa_pkg::ST_POS2:
            begin
                acc_y_next = {7'd0, pay};
                state_next = bfpa_pkg::ST_POS3;
            end
            bfpa_pkg::ST_POS3:
            begin
                acc_y_next = {pay, acc_y_reg[6:0]};
                state_next = bfpa_pkg::ST_POS4;
            end
            bfpa_pkg::ST_POS4:
            begin
                acc_heading_next = pay;
                state_next       = bfpa_pkg::ST_POS5;
            end
            bfpa_pkg::ST_POS5:
            begin
                latch_next.x       = acc_x_reg;
                latch_next.y       = acc_y_reg;
                latch_next.heading = {pay, acc_heading_reg};
                evt.pos_done       = byte_step;
                state_next         = bfpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bfpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bfpa_pkg::ST_IDLE;
            acc_dist_reg    <= '0;
            acc_angle_reg   <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
            latch_reg       <= '0;
        end
        else if (byte_step)
        begin
            state_reg       <= state_next;
            acc_dist_reg    <= acc_dist_next;
            acc_angle_reg   <= acc_angle_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
            acc_heading_reg <= acc_heading_next;
            latch_reg       <= latch_next;
        end
    end

    assign latch = latch_reg;

endmodule

`default_nettype wire

[rtl/core/bfpa_aging.sv]
// age counters and published opponent and position values
`default_nettype none

module bfpa_aging (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tick_step,
    input  wire logic              byte_step,
    input  bfpa_pkg::parse_evt_t   evt,
    input  bfpa_pkg::latch_t       latch,
    input  wire logic [7:0]        opp_age_limit,
    input  wire logic [7:0]        pos_age_limit,
    input  wire logic [11:0]       angle_offset,
    output bfpa_pkg::opp_pub_t     opp_pub_next,
    output bfpa_pkg::pos_pub_t     pos_pub_next
);

    logic [7:0] opp_age_reg, opp_age_next;
    logic [7:0] pos_age_reg, pos_age_next;
    bfpa_pkg::opp_pub_t opp_pub_reg;
    bfpa_pkg::pos_pub_t pos_pub_reg;
    logic [14:0] angle_sum;
    logic [14:0] angle_wrapped;
    logic [30:0] deg_prod;
    logic        opp_live;
    logic        pos_live;

    assign angle_sum     = {1'b0, latch.angle} + {3'd0, angle_offset};
    assign angle_wrapped = (angle_sum > bfpa_pkg::ANGLE_WRAP) ?
                           (angle_sum - bfpa_pkg::ANGLE_WRAP) : angle_sum;
    assign deg_prod      = angle_wrapped * bfpa_pkg::DEG_RECIP;

    assign opp_live = opp_age_reg < opp_age_limit;
    assign pos_live = pos_age_reg < pos_age_limit;

    always_comb
    begin
        opp_age_next = opp_age_reg;
        pos_age_next = pos_age_reg;
        opp_pub_next = opp_pub_reg;
        pos_pub_next = pos_pub_reg;
        if (tick_step)
        begin
            if (opp_live)
            begin
                opp_age_next               = opp_age_reg + 8'd1;
                opp_pub_next.present       = 1'b1;
                opp_pub_next.distance      = latch.distance;
                opp_pub_next.angle_tenths  = angle_wrapped;
                opp_pub_next.angle_degrees = deg_prod[bfpa_pkg::DEG_SHIFT +: 11];
            end
            else
            begin
                // absent: only the flag drops, values stay
                opp_pub_next.present = 1'b0;
            end
            if (pos_live)
            begin
                pos_age_next       = pos_age_reg + 8'd1;
                pos_pub_next.present = 1'b1;
                pos_pub_next.x     = latch.x;
                pos_pub_next.y     = latch.y;
                pos_pub_next.angle = latch.heading;
            end
            else
            begin
                pos_pub_next.present = 1'b0;
            end
        end
        else if (byte_step)
        begin
            if (evt.opp_done)
                opp_age_next = '0;
            if (evt.pos_done)
                pos_age_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opp_age_reg <= bfpa_pkg::AGE_ABSENT;
            pos_age_reg <= bfpa_pkg::AGE_ABSENT;
            opp_pub_reg <= '0;
            pos_pub_reg <= '0;
        end
        else
        begin
            opp_age_reg <= opp_age_next;
            pos_age_reg <= pos_age_next;
            opp_pub_reg <= opp_pub_next;
            pos_pub_reg <= pos_pub_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/beacon_frame_parser_with_aging.sv]
// Beacon frame parser with aging, top level.
// req channel: one item is either a received link byte (req_type 0, rx_byte)
// or a periodic tick (req_type 1). Each item yields exactly one item on the
// res channel holding the published opponent and position values as they
// stand after that item, plus frame-done flags for the byte that closed a frame.
// An item sits in an input register, then the parse/age logic loads the result
// register, which drives res.valid. One item is taken every cycle while
// res.ready stays high. The longest path is the opponent angle add, wrap and
// divide by ten on a tick.
// If res.ready is low the result register holds and the input register fills;
// req.ready drops only when both are full.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at the next clock
// edge and are expected only while no item is in flight.
// Reset (rst_n, async active low) idles the parser, sets both ages to absent,
// clears published values, and restores limits 50 and 3 and offset 449.
`default_nettype none

module beacon_frame_parser_with_aging (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    bfpa_req_if.sink                                  req,
    bfpa_res_if.source                                res,
    input  wire logic                                 cfg_we,
    input  wire logic [bfpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bfpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [7:0]  opp_age_limit_reg;
    logic [7:0]  pos_age_limit_reg;
    logic [11:0] angle_offset_reg;

    logic       in_valid_reg;
    logic       in_type_reg;
    logic [7:0] in_byte_reg;

    logic                  out_valid_reg;
    bfpa_pkg::opp_pub_t    out_opp_reg;
    bfpa_pkg::pos_pub_t    out_pos_reg;
    bfpa_pkg::parse_evt_t  out_evt_reg;

    logic                  step;
    logic                  tick_step;
    logic                  byte_step;
    bfpa_pkg::parse_evt_t  evt;
    bfpa_pkg::latch_t      latch;
    bfpa_pkg::opp_pub_t    opp_pub_next;
    bfpa_pkg::pos_pub_t    pos_pub_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opp_age_limit_reg <= bfpa_pkg::OPP_AGE_LIMIT_RST;
            pos_age_limit_reg <= bfpa_pkg::POS_AGE_LIMIT_RST;
            angle_offset_reg  <= bfpa_pkg::ANGLE_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfpa_pkg::CFG_OPP_AGE_LIMIT: opp_age_limit_reg <= cfg_data[7:0];
                bfpa_pkg::CFG_POS_AGE_LIMIT: pos_age_limit_reg <= cfg_data[7:0];
                bfpa_pkg::CFG_ANGLE_OFFSET:  angle_offset_reg  <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // the item in the input register is processed when the result register frees up
    assign step      = in_valid_reg && (!out_valid_reg || res.ready);
    assign tick_step = step && (in_type_reg == bfpa_pkg::REQ_TICK);
    assign byte_step = step && (in_type_reg == bfpa_pkg::REQ_BYTE);
    assign req.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_type_reg <= req.req_type;
            in_byte_reg <= req.rx_byte;
        end
    end

    bfpa_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_step (byte_step),
        .rx_byte   (in_byte_reg),
        .evt       (evt),
        .latch     (latch)
    );

    bfpa_aging u_aging (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_step     (tick_step),
        .byte_step     (byte_step),
        .evt           (evt),
        .latch         (latch),
        .opp_age_limit (opp_age_limit_reg),
        .pos_age_limit (pos_age_limit_reg),
        .angle_offset  (angle_offset_reg),
        .opp_pub_next  (opp_pub_next),
        .pos_pub_next  (pos_pub_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_opp_reg <= opp_pub_next;
            out_pos_reg <= pos_pub_next;
            out_evt_reg <= byte_step ? evt : '0;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.opp_present       = out_opp_reg.present;
    assign res.opp_distance      = out_opp_reg.distance;
    assign res.opp_angle_tenths  = out_opp_reg.angle_tenths;
    assign res.opp_angle_degrees = out_opp_reg.angle_degrees;
    assign res.pos_present       = out_pos_reg.present;
    assign res.pos_x_out         = out_pos_reg.x;
    assign res.pos_y_out         = out_pos_reg.y;
    assign res.pos_angle_out     = out_pos_reg.angle;
    assign res.opp_frame_done    = out_evt_reg.opp_done;
    assign res.pos_frame_done    = out_evt_reg.pos_done;

    // a tick never reports a finished frame
    a_tick_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        tick_step |=> (!out_evt_reg.opp_done && !out_evt_reg.pos_done))
        else $error("frame done flagged on a tick");

    // one byte closes at most one frame
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(evt.opp_done && evt.pos_done))
        else $error("both frames done on one byte");

    // with the result register empty the input side is never stalled
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("input stalled with empty result register");

    // a finished opponent frame restarts aging
    a_opp_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_step && evt.opp_done) |=> (u_aging.opp_age_reg == 8'd0))
        else $error("opponent age not restarted");

endmodule

`default_nettype wire

[verif/tb_beacon_frame_parser_with_aging.sv]
// testbench for the beacon frame parser: directed table, random frames, self-checking predictor
module tb_beacon_frame_parser_with_aging;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bfpa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 190;
    localparam int NUM_PHASES = 9;

    typedef struct packed {
        bfpa_pkg::opp_pub_t opp;
        bfpa_pkg::pos_pub_t pos;
        logic               opp_done;
        logic               pos_done;
    } report_t;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        bit         typed;
        report_t    want;
    } vector_t;

    localparam report_t NO_DATA = '0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [bfpa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bfpa_pkg::CFG_DATA_W-1:0] cfg_data;

    bfpa_req_if req_ch ();
    bfpa_res_if res_ch ();

    beacon_frame_parser_with_aging u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [7:0]             lim_opp;
    logic [7:0]             lim_pos;
    logic [11:0]            offset_tenths;
    bfpa_pkg::parse_state_t frame_state;
    bfpa_pkg::latch_t       acc;
    bfpa_pkg::latch_t       held;
    logic [7:0]             age_opp;
    logic [7:0]             age_pos;
    bfpa_pkg::opp_pub_t     shown_opp;
    bfpa_pkg::pos_pub_t     shown_pos;

    report_t pending_reports[$];
    vector_t directed[$];
    int      fail_count;
    int      quiet_cycles;
    int      hold_off_request;
    bit      sender_idles;
    bit      receiver_idles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic reset_model();
        lim_opp       = bfpa_pkg::OPP_AGE_LIMIT_RST;
        lim_pos       = bfpa_pkg::POS_AGE_LIMIT_RST;
        offset_tenths = bfpa_pkg::ANGLE_OFFSET_RST;
        frame_state   = bfpa_pkg::ST_IDLE;
        acc           = '0;
        held          = '0;
        age_opp       = bfpa_pkg::AGE_ABSENT;
        age_pos       = bfpa_pkg::AGE_ABSENT;
        shown_opp     = '0;
        shown_pos     = '0;
    endtask

    function automatic report_t parse_and_age(logic kind, logic [7:0] b);
        report_t     r;
        logic [15:0] sum;
        logic [13:0] hi;
        r  = NO_DATA;
        hi = {b[6:0], 7'd0};
        if (kind == bfpa_pkg::REQ_BYTE)
        begin
            // any byte with bit 7 clear is a command and aborts the frame
            if (!b[7])
                frame_state = bfpa_pkg::ST_IDLE;
            case (frame_state)
                bfpa_pkg::ST_IDLE:
                begin
                    if (b == bfpa_pkg::CMD_OPP)
                    begin
                        frame_state  = bfpa_pkg::ST_OPP0;
                        acc.distance = '0;
                        acc.angle    = '0;
                    end
                    else if (b == bfpa_pkg::CMD_POS)
                    begin
                        frame_state = bfpa_pkg::ST_POS0;
                        acc.x       = '0;
                        acc.y       = '0;
                        acc.heading = '0;
                    end
                end
                bfpa_pkg::ST_OPP0:
                begin
                    acc.distance = {7'd0, b[6:0]};
                    frame_state  = bfpa_pkg::ST_OPP1;
                end
                bfpa_pkg::ST_OPP1:
                begin
                    acc.distance = acc.distance | hi;
                    frame_state  = bfpa_pkg::ST_OPP2;
                end
                bfpa_pkg::ST_OPP2:
                begin
                    acc.angle   = {7'd0, b[6:0]};
                    frame_state = bfpa_pkg::ST_OPP3;
                end
                bfpa_pkg::ST_OPP3:
                begin
                    acc.angle     = acc.angle | hi;
                    held.distance = acc.distance;
                    held.angle    = acc.angle;
                    age_opp       = '0;
                    r.opp_done    = 1'b1;
                    frame_state   = bfpa_pkg::ST_IDLE;
                end
                bfpa_pkg::ST_POS0:
                begin
                    acc.x       = {7'd0, b[6:0]};
                    frame_state = bfpa_pkg::ST_POS1;
                end
                bfpa_pkg::ST_POS1:
                begin
                    acc.x       = acc.x | hi;
                    frame_state = bfpa_pkg::ST_POS2;
                end
                bfpa_pkg::ST_POS2:
                begin
                    acc.y       = {7'd0, b[6:0]};
                    frame_state = bfpa_pkg::ST_POS3;
                end
                bfpa_pkg::ST_POS3:
                begin
                    acc.y       = acc.y | hi;
                    frame_state = bfpa_pkg::ST_POS4;
                end
                bfpa_pkg::ST_POS4:
                begin
                    acc.heading = {7'd0, b[6:0]};
                    frame_state = bfpa_pkg::ST_POS5;
                end
                bfpa_pkg::ST_POS5:
                begin
                    acc.heading  = acc.heading | hi;
                    held.x       = acc.x;
                    held.y       = acc.y;
                    held.heading = acc.heading;
                    age_pos      = '0;
                    r.pos_done   = 1'b1;
                    frame_state  = bfpa_pkg::ST_IDLE;
                end
                default:
                    frame_state = bfpa_pkg::ST_IDLE;
            endcase
        end
        else
        begin
            if (age_opp < lim_opp)
            begin
                sum = {2'd0, held.angle} + {4'd0, offset_tenths};
                age_opp = age_opp + 8'd1;
                // wrapped only once, even with an offset past the full turn
                if (sum > {1'b0, bfpa_pkg::ANGLE_WRAP})
                    sum = sum - {1'b0, bfpa_pkg::ANGLE_WRAP};
                shown_opp.present       = 1'b1;
                shown_opp.distance      = held.distance;
                shown_opp.angle_tenths  = sum[14:0];
                shown_opp.angle_degrees = 11'(sum / 16'd10);
            end
            else
                shown_opp.present = 1'b0;
            if (age_pos < lim_pos)
            begin
                age_pos = age_pos + 8'd1;
                shown_pos.present = 1'b1;
                shown_pos.x       = held.x;
                shown_pos.y       = held.y;
                shown_pos.angle   = held.heading;
            end
            else
                shown_pos.present = 1'b0;
        end
        r.opp = shown_opp;
        r.pos = shown_pos;
        return r;
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] b, input bit typed,
                             input report_t want);
        report_t predicted;
        while (sender_idles && $urandom_range(99) < 28)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.rx_byte  <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = parse_and_age(kind, b);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic send_tick();
        send_item(bfpa_pkg::REQ_TICK, 8'($urandom), 1'b0, NO_DATA);
    endtask

    // command byte, then payload bytes with the odd tick in between
    task automatic send_frame(input logic [7:0] cmd, input int n_payload, inout int count);
        send_item(bfpa_pkg::REQ_BYTE, cmd, 1'b0, NO_DATA);
        count++;
        for (int i = 0; i < n_payload; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_tick();
                count++;
            end
            send_item(bfpa_pkg::REQ_BYTE, {1'b1, 7'($urandom)}, 1'b0, NO_DATA);
            count++;
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [bfpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bfpa_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            bfpa_pkg::CFG_OPP_AGE_LIMIT: lim_opp = val[7:0];
            bfpa_pkg::CFG_POS_AGE_LIMIT: lim_pos = val[7:0];
            bfpa_pkg::CFG_ANGLE_OFFSET:  offset_tenths = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result item with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("opp_present", want.opp.present, res_ch.opp_present);
                check_field("opp_distance", want.opp.distance, res_ch.opp_distance);
                check_field("opp_angle_tenths", want.opp.angle_tenths,
                            res_ch.opp_angle_tenths);
                check_field("opp_angle_degrees", want.opp.angle_degrees,
                            res_ch.opp_angle_degrees);
                check_field("pos_present", want.pos.present, res_ch.pos_present);
                check_field("pos_x_out", want.pos.x, res_ch.pos_x_out);
                check_field("pos_y_out", want.pos.y, res_ch.pos_y_out);
                check_field("pos_angle_out", want.pos.angle, res_ch.pos_angle_out);
                check_field("opp_frame_done", want.opp_done, res_ch.opp_frame_done);
                check_field("pos_frame_done", want.pos_done, res_ch.pos_frame_done);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("beacon_frame_parser_with_aging: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result receiver
    initial
    begin
        int n;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request > 0)
            begin
                n = hold_off_request;
                hold_off_request = 0;
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_ch.ready <= receiver_idles ? ($urandom_range(99) >= 28) : 1'b1;
        end
    end

    initial
    begin
        int count;
        int sel;
        logic [7:0] o_lim;
        logic [7:0] p_lim;
        logic [11:0] off;
        report_t first_angle;

        fail_count       = 0;
        quiet_cycles     = 0;
        hold_off_request = 0;
        sender_idles     = 1'b1;
        receiver_idles   = 1'b1;
        reset_model();
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= bfpa_pkg::REQ_BYTE;
        req_ch.rx_byte  <= 8'h00;
        cfg_we          <= 1'b0;
        cfg_index       <= bfpa_pkg::CFG_OPP_AGE_LIMIT;
        cfg_data        <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first opponent tick after a full-scale frame, default offset wraps it
        first_angle = NO_DATA;
        first_angle.opp = '{present: 1'b1, distance: 14'd16383, angle_tenths: 15'd13232,
                            angle_degrees: 11'd1323};

        directed.push_back('{bfpa_pkg::REQ_TICK, 8'h00, 1'b1, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'h85, 1'b1, NO_DATA});   // payload while idle
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'h7F, 1'b1, NO_DATA});   // unknown command
        directed.push_back('{bfpa_pkg::REQ_BYTE, bfpa_pkg::CMD_OPP, 1'b1, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'hFF, 1'b1,
                             report_t'{opp: '0, pos: '0, opp_done: 1'b1, pos_done: 1'b0}});
        directed.push_back('{bfpa_pkg::REQ_TICK, 8'hFF, 1'b1, first_angle});
        directed.push_back('{bfpa_pkg::REQ_BYTE, bfpa_pkg::CMD_POS, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'h80, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'h80, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'h80, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'hC0, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_TICK, 8'h55, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, bfpa_pkg::CMD_OPP, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'h81, 1'b0, NO_DATA});
        // aborts the opponent frame
        directed.push_back('{bfpa_pkg::REQ_BYTE, bfpa_pkg::CMD_POS, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'h7F, 1'b0, NO_DATA});   // aborts, then ignored
        directed.push_back('{bfpa_pkg::REQ_BYTE, 8'h90, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_TICK, 8'hAA, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_TICK, 8'h00, 1'b0, NO_DATA});
        directed.push_back('{bfpa_pkg::REQ_TICK, 8'h33, 1'b0, NO_DATA});   // position ages out

        foreach (directed[i])
            send_item(directed[i].kind, directed[i].data, directed[i].typed, directed[i].want);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            repeat (4) @(posedge clk);
            case (phase)
                0:
                begin
                    o_lim = 8'd0;
                    p_lim = 8'd0;
                    off   = 12'd0;
                end
                1:
                begin
                    o_lim = 8'd255;
                    p_lim = 8'd255;
                    off   = 12'd4095;
                end
                2:
                begin
                    o_lim = 8'd1;
                    p_lim = 8'd1;
                    off   = 12'd3600;
                end
                3:
                begin
                    o_lim = 8'd2;
                    p_lim = 8'd6;
                    off   = 12'd3151;
                end
                NUM_PHASES - 1:
                begin
                    o_lim = bfpa_pkg::OPP_AGE_LIMIT_RST;
                    p_lim = bfpa_pkg::POS_AGE_LIMIT_RST;
                    off   = bfpa_pkg::ANGLE_OFFSET_RST;
                end
                default:
                begin
                    o_lim = 8'($urandom_range(12));
                    p_lim = 8'($urandom_range(12));
                    off   = 12'($urandom);
                end
            endcase
            // upper data bits go to the 8-bit limits too and must be dropped
            write_reg(bfpa_pkg::CFG_OPP_AGE_LIMIT, {4'($urandom), o_lim});
            write_reg(bfpa_pkg::CFG_POS_AGE_LIMIT, {4'($urandom), p_lim});
            write_reg(bfpa_pkg::CFG_ANGLE_OFFSET, off);
            write_reg(CFG_UNUSED, 12'($urandom));

            sender_idles   = (phase != 4);
            receiver_idles = (phase != 4);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if (count > PHASE_ITEMS / 2 && count < PHASE_ITEMS / 2 + 8)
                begin
                    if (phase == 1)
                        hold_off_request = 60;
                    else if (phase == 2)
                        drain();
                end
                sel = $urandom_range(99);
                if (sel < 40)
                    send_frame(bfpa_pkg::CMD_OPP, 4, count);
                else if (sel < 65)
                    send_frame(bfpa_pkg::CMD_POS, 6, count);
                else if (sel < 85)
                begin
                    send_tick();
                    count++;
                end
                else if (sel < 93)
                begin
                    // truncated frame, the next command cuts it off
                    if ($urandom_range(1) == 0)
                        send_frame(bfpa_pkg::CMD_OPP, $urandom_range(3), count);
                    else
                        send_frame(bfpa_pkg::CMD_POS, $urandom_range(5), count);
                end
                else
                begin
                    send_item(bfpa_pkg::REQ_BYTE, 8'($urandom), 1'b0, NO_DATA);
                    count++;
                end
            end
        end

        drain();
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("beacon_frame_parser_with_aging: match");
        else
            $display("beacon_frame_parser_with_aging: mismatch");
        $finish;
    end

endmodule
